### hdl/cuid_pkg.sv
// Shared types and codes for the cyclic unique identifier allocator.
package cuid_pkg;

    localparam int REQ_W    = 1;
    localparam int RID_W    = 7;
    localparam int NEW_ID_W = 7;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 1'b0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_FREE,
        ST_FIND_BOUND,
        ST_ALLOC_WR,
        ST_REL_CHK,
        ST_DONE
    } cuid_state_t;

    typedef struct packed {
        logic [NEW_ID_W-1:0] new_id;
        logic [STATUS_W-1:0] status;
    } cuid_result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } cuid_mem_ctl_t;

endpackage

### hdl/cuid_bitmap.sv
// Occupancy bitmap: one bit per identifier, synchronous read with registered read data.
module cuid_bitmap #(
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                   aclk,
    input  cuid_pkg::cuid_mem_ctl_t ctl,
    input  logic [AW-1:0]          wr_addr,
    input  logic [AW-1:0]          rd_addr,
    output logic                   rd_data
);
    import cuid_pkg::*;

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= ctl.wr_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cuid_ctrl.sv
// Sequencer: clearing sweep, allocate rescans and release lookups on the bitmap.
module cuid_ctrl #(
    parameter int MAX_ID   = 128,
    parameter int MAX_LIVE = 64,
    localparam int AW = $clog2(MAX_ID)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cuid_pkg::REQ_W-1:0]          in_req_type,
    input  logic [cuid_pkg::RID_W-1:0]          in_release_id,
    output logic                                res_valid,
    input  logic                                res_ready,
    output cuid_pkg::cuid_result_t              res,
    output cuid_pkg::cuid_mem_ctl_t             mem_ctl,
    output logic [AW-1:0]                       mem_wr_addr,
    output logic [AW-1:0]                       mem_rd_addr,
    input  logic                                mem_rd_data
);
    import cuid_pkg::*;

    localparam int BW = $clog2(MAX_ID + 1);
    localparam int CW = $clog2(MAX_LIVE + 1);
    localparam logic [AW-1:0] ID_LAST = AW'(MAX_ID - 1);
    localparam logic [AW-1:0] ID_ONE  = AW'(1);
    localparam logic [BW-1:0] BOUND_TOP = BW'(MAX_ID);

    cuid_state_t state_reg, state_next;
    logic [BW-1:0] last_reg, last_next;
    logic [BW-1:0] bound_reg, bound_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] chk_reg, chk_next;
    logic [AW-1:0] cand_reg, cand_next;
    cuid_result_t  res_reg, res_next;

    logic          accept;
    logic          is_full;
    logic          rid_bad;
    logic [BW:0]   cand_sum;
    logic          cand_wrap;
    logic          need_scan;
    logic [AW-1:0] cand_start;

    // next identifier in the cyclic order, skipping 0
    function automatic logic [AW-1:0] id_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == ID_LAST) begin
            r = ID_ONE;
        end else begin
            r = a + ID_ONE;
        end
        return r;
    endfunction

    assign accept    = in_valid && in_ready;
    assign is_full   = (count_reg >= CW'(MAX_LIVE)) || (32'(count_reg) >= 32'(MAX_ID - 1));
    assign rid_bad   = (in_release_id == '0) || (32'(in_release_id) >= 32'(MAX_ID));
    assign cand_sum  = (BW + 1)'(last_reg) + (BW + 1)'(1);
    assign cand_wrap = cand_sum >= (BW + 1)'(MAX_ID);
    assign need_scan = cand_wrap || (cand_sum >= (BW + 1)'(bound_reg));
    assign cand_start = cand_wrap ? ID_ONE : AW'(cand_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            last_reg  <= BOUND_TOP;
            bound_reg <= BOUND_TOP;
            count_reg <= '0;
            chk_reg   <= '0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            bound_reg <= bound_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        res_reg  <= res_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (chk_reg == ID_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_req_type == REQ_RELEASE) begin
                        state_next = rid_bad ? ST_DONE : ST_REL_CHK;
                    end else if (is_full) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = need_scan ? ST_FIND_FREE : ST_ALLOC_WR;
                    end
                end
            end
            ST_FIND_FREE: begin
                if (!mem_rd_data) begin
                    state_next = (chk_reg == ID_LAST) ? ST_ALLOC_WR : ST_FIND_BOUND;
                end
            end
            ST_FIND_BOUND: begin
                if (mem_rd_data || chk_reg == ID_LAST) begin
                    state_next = ST_ALLOC_WR;
                end
            end
            ST_ALLOC_WR: state_next = ST_DONE;
            ST_REL_CHK:  state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // datapath and memory port
    always_comb begin
        last_next   = last_reg;
        bound_next  = bound_reg;
        count_next  = count_reg;
        chk_next    = chk_reg;
        cand_next   = cand_reg;
        res_next    = res_reg;
        mem_ctl     = '{rd_en: 1'b0, wr_en: 1'b0, wr_bit: 1'b0};
        mem_wr_addr = chk_reg;
        mem_rd_addr = chk_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                chk_next      = chk_reg + ID_ONE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    res_next = '{new_id: '0, status: STATUS_OK};
                    if (in_req_type == REQ_RELEASE) begin
                        if (rid_bad) begin
                            res_next.status = STATUS_NOT_FOUND;
                        end else begin
                            mem_ctl.rd_en = 1'b1;
                            mem_rd_addr   = AW'(in_release_id);
                            chk_next      = AW'(in_release_id);
                        end
                    end else if (is_full) begin
                        res_next.status = STATUS_FULL;
                    end else begin
                        cand_next     = cand_start;
                        mem_ctl.rd_en = need_scan;
                        mem_rd_addr   = cand_start;
                        chk_next      = cand_start;
                    end
                end
            end
            ST_FIND_FREE: begin
                // reads stream one address per cycle; the read data is registered in the bitmap
                mem_ctl.rd_en = 1'b1;
                if (!mem_rd_data) begin
                    cand_next   = chk_reg;
                    mem_rd_addr = chk_reg + ID_ONE;
                    chk_next    = chk_reg + ID_ONE;
                    if (chk_reg == ID_LAST) begin
                        bound_next    = BOUND_TOP;
                        mem_ctl.rd_en = 1'b0;
                    end
                end else begin
                    mem_rd_addr = id_inc(chk_reg);
                    chk_next    = id_inc(chk_reg);
                end
            end
            ST_FIND_BOUND: begin
                if (mem_rd_data) begin
                    bound_next = BW'(chk_reg);
                end else if (chk_reg == ID_LAST) begin
                    bound_next = BOUND_TOP;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    mem_rd_addr   = chk_reg + ID_ONE;
                    chk_next      = chk_reg + ID_ONE;
                end
            end
            ST_ALLOC_WR: begin
                mem_ctl      = '{rd_en: 1'b0, wr_en: 1'b1, wr_bit: 1'b1};
                mem_wr_addr  = cand_reg;
                last_next    = BW'(cand_reg);
                count_next   = count_reg + CW'(1);
                res_next     = '{new_id: NEW_ID_W'(cand_reg), status: STATUS_OK};
            end
            ST_REL_CHK: begin
                if (mem_rd_data) begin
                    mem_ctl.wr_en = 1'b1;
                    if (count_reg != '0) begin
                        count_next = count_reg - CW'(1);
                    end
                end else begin
                    res_next.status = STATUS_NOT_FOUND;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

endmodule

### hdl/cyclic_unique_id_allocator.sv
// Top level of the cyclic unique identifier allocator: sequencer, bitmap, result register.
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  request | s_valid s_ready s_req_type          | in
//          | s_release_id                        |
//  result  | m_valid m_ready m_new_id m_status   | out
//
// One request at a time. A release passes the lookup state ST_REL_CHK and a fast-path
// allocate the write state ST_ALLOC_WR before the result is ready; a refused request goes
// there directly; a rescan visits one bitmap entry per cycle on the single read port.
// After reset a clearing sweep writes every bitmap entry to zero with s_ready low.
// The result register lets the next request start in the cycle after the result is loaded,
// while m_valid waits on m_ready; a second result then waits in the sequencer.
module cyclic_unique_id_allocator #(
    parameter int MAX_ID   = 128,
    parameter int MAX_LIVE = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cuid_pkg::REQ_W-1:0]        s_req_type,
    input  logic [cuid_pkg::RID_W-1:0]        s_release_id,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cuid_pkg::NEW_ID_W-1:0]     m_new_id,
    output logic [cuid_pkg::STATUS_W-1:0]     m_status
);
    import cuid_pkg::*;

    localparam int AW = $clog2(MAX_ID);

    cuid_mem_ctl_t mem_ctl;
    logic [AW-1:0] mem_wr_addr;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_rd_data;
    logic          res_valid;
    logic          res_ready;
    cuid_result_t  res;

    logic          m_valid_reg, m_valid_next;
    cuid_result_t  m_res_reg, m_res_next;

    cuid_ctrl #(
        .MAX_ID   (MAX_ID),
        .MAX_LIVE (MAX_LIVE)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_req_type   (s_req_type),
        .in_release_id (s_release_id),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_ctl       (mem_ctl),
        .mem_wr_addr   (mem_wr_addr),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    cuid_bitmap #(
        .DEPTH (MAX_ID)
    ) u_bitmap (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_new_id = m_res_reg.new_id;
    assign m_status = m_res_reg.status;

`ifndef SYNTHESIS
    // one request in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // bitmap port never reads and writes in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("bitmap read and write in the same cycle");

    // a failed request never carries an identifier
    a_fail_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_new_id == '0)
        else $error("identifier reported with a failing status");

    // a result is handed to the output register only when it has room
    a_res_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && m_valid && !m_ready |=> $stable(m_res_reg))
        else $error("result register overwritten while stalled");
`endif

endmodule

### tb/sv/cuid_result_checker.sv
// Checker for the identifier allocator: tracks live ids, predicts each answer, compares in order.
module cuid_result_checker #(
    parameter int MAX_ID   = 128,
    parameter int MAX_LIVE = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [cuid_pkg::REQ_W-1:0]    s_req_type,
    input  logic [cuid_pkg::RID_W-1:0]    s_release_id,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [cuid_pkg::NEW_ID_W-1:0] m_new_id,
    input  logic [cuid_pkg::STATUS_W-1:0] m_status,
    output int                            err_count,
    output int                            pending,
    output int                            results_seen,
    output int                            full_seen,
    output int                            missing_seen,
    output logic [MAX_ID-1:0]             live_map
);
    timeunit 1ns;
    timeprecision 1ps;

    import cuid_pkg::*;

    int last_given;
    int safe_bound;
    int live_count;

    cuid_result_t awaited_results[$];
    cuid_result_t due;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Advances the live-id state by one request and returns the answer it should get.
    function automatic cuid_result_t serve_request(input logic [REQ_W-1:0] req,
                                                   input logic [RID_W-1:0] rid);
        cuid_result_t res;
        int cand;
        int n;
        bit rescan;
        res.new_id = '0;
        res.status = STATUS_OK;
        if (req == REQ_ALLOC) begin
            if (live_count >= MAX_LIVE || live_count >= MAX_ID - 1) begin
                res.status = STATUS_FULL;
            end else begin
                cand   = last_given + 1;
                rescan = 1'b0;
                if (cand >= MAX_ID) begin
                    cand   = 1;
                    rescan = 1'b1;
                end else if (cand >= safe_bound) begin
                    rescan = 1'b1;
                end
                if (rescan) begin
                    for (n = 0; n < MAX_ID && live_map[cand]; n++) begin
                        cand++;
                        if (cand >= MAX_ID) begin
                            cand = 1;
                        end
                    end
                    // bound is the nearest live id above the pick
                    safe_bound = MAX_ID;
                    for (n = cand + 1; n < MAX_ID; n++) begin
                        if (live_map[n]) begin
                            safe_bound = n;
                            break;
                        end
                    end
                end
                last_given     = cand;
                live_map[cand] = 1'b1;
                live_count++;
                res.new_id = NEW_ID_W'(cand);
            end
        end else begin
            res.status = STATUS_NOT_FOUND;
            if (rid != 0 && int'(rid) < MAX_ID) begin
                if (live_map[rid]) begin
                    live_map[rid] = 1'b0;
                    live_count--;
                    res.status = STATUS_OK;
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            live_map   = '0;
            last_given = MAX_ID;
            safe_bound = MAX_ID;
            live_count = 0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result new_id=%0d status=%0d with no request open",
                                              m_new_id, m_status));
                end else begin
                    due = awaited_results.pop_front();
                    if (due.status == STATUS_FULL) begin
                        full_seen++;
                    end
                    if (due.status == STATUS_NOT_FOUND) begin
                        missing_seen++;
                    end
                    if (m_new_id !== due.new_id) begin
                        report_mismatch($sformatf("new_id %0d, wanted %0d", m_new_id, due.new_id));
                    end
                    if (m_status !== due.status) begin
                        report_mismatch($sformatf("status %0d, wanted %0d", m_status, due.status));
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(serve_request(s_req_type, s_release_id));
            end
        end
        pending = awaited_results.size();
    end

endmodule

### tb/sv/cyclic_unique_id_allocator_tb.sv
// Testbench top for the identifier allocator: reset, request stimulus, ready stalls, verdict.
module cyclic_unique_id_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cuid_pkg::*;

    localparam int MAX_ID       = 128;
    localparam int MAX_LIVE     = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * MAX_ID + 16;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic [RID_W-1:0]    s_release_id;
    logic                m_valid;
    logic                m_ready;
    logic [NEW_ID_W-1:0] m_new_id;
    logic [STATUS_W-1:0] m_status;

    int               err_count;
    int               pending;
    int               results_seen;
    int               full_seen;
    int               missing_seen;
    logic [MAX_ID-1:0] live_map;

    bit idling = 1'b1;
    int requests_sent = 0;

    cyclic_unique_id_allocator #(
        .MAX_ID   (MAX_ID),
        .MAX_LIVE (MAX_LIVE)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_release_id (s_release_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_id     (m_new_id),
        .m_status     (m_status)
    );

    cuid_result_checker #(
        .MAX_ID   (MAX_ID),
        .MAX_LIVE (MAX_LIVE)
    ) u_result_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_release_id (s_release_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_id     (m_new_id),
        .m_status     (m_status),
        .err_count    (err_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .missing_seen (missing_seen),
        .live_map     (live_map)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [RID_W-1:0] rid);
        int gap;
        if (idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_release_id <= rid;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Hold off new requests until every open answer is back.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Some id that is live right now, searched from a random start; any id if none.
    function automatic logic [RID_W-1:0] pick_live();
        int start;
        int k;
        int idx;
        start = $urandom_range(1, MAX_ID - 1);
        for (k = 0; k < MAX_ID - 1; k++) begin
            idx = 1 + (start - 1 + k) % (MAX_ID - 1);
            if (live_map[idx]) begin
                return RID_W'(idx);
            end
        end
        return RID_W'($urandom_range(1, MAX_ID - 1));
    endfunction

    // Mix of allocates, releases of live ids, and releases of arbitrary ids.
    task automatic run_phase(input int count, input int alloc_pct, input int live_pct);
        int i;
        int r;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                send_request(REQ_ALLOC, RID_W'($urandom_range(0, 127)));
            end else if (r < alloc_pct + live_pct) begin
                send_request(REQ_RELEASE, pick_live());
            end else begin
                send_request(REQ_RELEASE, RID_W'($urandom_range(0, 127)));
            end
        end
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idling && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("watchdog: %0d cycles without any handshake", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_ALLOC;
        s_release_id = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first allocate wraps from the reset value and rescans
        send_request(REQ_ALLOC, 7'd0);
        send_request(REQ_RELEASE, 7'd0);
        send_request(REQ_RELEASE, 7'd127);
        send_request(REQ_RELEASE, 7'd1);
        send_request(REQ_RELEASE, 7'd1);
        send_request(REQ_ALLOC, 7'd127);
        send_request(REQ_ALLOC, 7'd85);
        send_request(REQ_ALLOC, 7'd42);
        // hole below the last id handed out
        send_request(REQ_RELEASE, 7'd3);
        send_request(REQ_RELEASE, 7'd85);
        send_request(REQ_RELEASE, 7'd42);
        send_request(REQ_ALLOC, 7'd0);
        send_request(REQ_ALLOC, 7'd127);
        send_request(REQ_RELEASE, 7'd127);
        send_request(REQ_RELEASE, 7'd2);
        send_request(REQ_RELEASE, 7'd4);
        settle();

        run_phase(300, 85, 10);
        run_phase(450, 50, 40);
        run_phase(250, 15, 75);
        settle();
        run_phase(300, 80, 15);
        run_phase(200, 50, 40);

        idling = 1'b0;
        run_phase(250, 55, 40);
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d requests, %0d answers checked", requests_sent, results_seen);
        $display("answers included %0d full-table refusals and %0d unknown releases",
                 full_seen, missing_seen);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
hdl/cuid_pkg.sv
hdl/cuid_bitmap.sv
hdl/cuid_ctrl.sv
hdl/cyclic_unique_id_allocator.sv
tb/sv/cuid_result_checker.sv
tb/sv/cyclic_unique_id_allocator_tb.sv
